// ----- sv/tlsf_pkg.sv -----
package tlsf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [15:0] SETTLE_RESET = 16'd40;
  localparam logic [7:0]  NIBBLE_MASK  = 8'h0F;

  // register indexes, taken from paddr[2]
  localparam logic REG_SETTLE_MS = 1'b0;

  typedef enum logic [1:0] {
    KIND_NO_FINGER,
    KIND_BAD_COORD,
    KIND_COORD
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] nx;
    logic [11:0] ny;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic               touching;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic               ever_seen;
  } result_t;

endpackage

// ----- sv/tlsf_front.sv -----
module tlsf_front (
  input  logic                 count_read_ok,
  input  logic [7:0]           finger_count,
  input  logic                 coords_read_ok,
  input  logic [7:0]           x_high,
  input  logic [7:0]           x_low,
  input  logic [7:0]           y_high,
  input  logic [7:0]           y_low,
  input  logic [31:0]          now_ms,
  output tlsf_pkg::item_t      item
);

  logic [7:0] xh_masked;
  logic [7:0] yh_masked;

  assign xh_masked = x_high & tlsf_pkg::NIBBLE_MASK;
  assign yh_masked = y_high & tlsf_pkg::NIBBLE_MASK;

  always_comb begin
    if (!count_read_ok || finger_count == 8'd0) begin
      item.kind = tlsf_pkg::KIND_NO_FINGER;
    end else if (!coords_read_ok) begin
      item.kind = tlsf_pkg::KIND_BAD_COORD;
    end else begin
      item.kind = tlsf_pkg::KIND_COORD;
    end
    item.nx     = {xh_masked[3:0], x_low};
    item.ny     = {yh_masked[3:0], y_low};
    item.now_ms = now_ms;
  end

endmodule

// ----- sv/tlsf_queue.sv -----
module tlsf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlsf_pkg::item_t push_item,
  input  logic            pop,
  output tlsf_pkg::item_t head_item,
  output logic            empty,
  output logic            full
);

  tlsf_pkg::item_t                 mem [tlsf_pkg::QUEUE_DEPTH];
  logic [tlsf_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tlsf_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tlsf_pkg::QCNT_W-1:0]     count;

  assign empty     = (count == '0);
  assign full      = (count == tlsf_pkg::QCNT_W'(tlsf_pkg::QUEUE_DEPTH));
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/tlsf_back.sv -----
module tlsf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       settle_ms,
  input  tlsf_pkg::item_t   head_item,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tlsf_pkg::result_t out_result
);

  logic        contact_down, contact_down_next;
  logic [15:0] held_x, held_x_next;
  logic [15:0] held_y, held_y_next;
  logic [15:0] motion_x, motion_x_next;
  logic [15:0] motion_y, motion_y_next;
  logic        settling, settling_next;
  logic [31:0] quiet_start, quiet_start_next;
  logic        seen_flag, seen_flag_next;
  tlsf_pkg::result_t result_next;

  logic [31:0] qs;
  logic [31:0] quiet_len;
  logic [15:0] nx16;
  logic [15:0] ny16;

  assign pop  = head_valid && (!out_valid || out_ready);
  assign nx16 = {4'd0, head_item.nx};
  assign ny16 = {4'd0, head_item.ny};
  assign qs        = settling ? quiet_start : head_item.now_ms;
  assign quiet_len = head_item.now_ms - qs;

  always_comb begin
    contact_down_next = contact_down;
    held_x_next       = held_x;
    held_y_next       = held_y;
    motion_x_next     = motion_x;
    motion_y_next     = motion_y;
    settling_next     = settling;
    quiet_start_next  = quiet_start;
    seen_flag_next    = seen_flag;
    result_next.touching = 1'b0;
    result_next.x_pos    = '0;
    result_next.y_pos    = '0;

    case (head_item.kind)
      tlsf_pkg::KIND_NO_FINGER: begin
        if (contact_down) begin
          settling_next    = 1'b1;
          quiet_start_next = qs;
          if (quiet_len < {16'd0, settle_ms}) begin
            // still inside the settle window: extrapolate
            held_x_next          = held_x + motion_x;
            held_y_next          = held_y + motion_y;
            result_next.touching = 1'b1;
            result_next.x_pos    = held_x_next;
            result_next.y_pos    = held_y_next;
          end else begin
            contact_down_next = 1'b0;
            settling_next     = 1'b0;
            motion_x_next     = '0;
            motion_y_next     = '0;
          end
        end
      end
      tlsf_pkg::KIND_COORD: begin
        seen_flag_next = 1'b1;
        if (!contact_down) begin
          motion_x_next = '0;
          motion_y_next = '0;
        end else if (nx16 != held_x || ny16 != held_y) begin
          motion_x_next = nx16 - held_x;
          motion_y_next = ny16 - held_y;
        end
        contact_down_next    = 1'b1;
        settling_next        = 1'b0;
        held_x_next          = nx16;
        held_y_next          = ny16;
        result_next.touching = 1'b1;
        result_next.x_pos    = nx16;
        result_next.y_pos    = ny16;
      end
      default: begin
        // bad coordinate read: hold the last position while down
        if (contact_down) begin
          result_next.touching = 1'b1;
          result_next.x_pos    = held_x;
          result_next.y_pos    = held_y;
        end
      end
    endcase
    result_next.ever_seen = seen_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_down <= 1'b0;
      held_x       <= '0;
      held_y       <= '0;
      motion_x     <= '0;
      motion_y     <= '0;
      settling     <= 1'b0;
      quiet_start  <= '0;
      seen_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        contact_down <= contact_down_next;
        held_x       <= held_x_next;
        held_y       <= held_y_next;
        motion_x     <= motion_x_next;
        motion_y     <= motion_y_next;
        settling     <= settling_next;
        quiet_start  <= quiet_start_next;
        seen_flag    <= seen_flag_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= result_next;
    end
  end

  a_touch_implies_seen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.touching |-> out_result.ever_seen)
    else $error("touching reported before any coordinate was seen");

  a_motion_clear_when_up: assert property (@(posedge clk) disable iff (rst)
    !contact_down |-> (motion_x == 16'd0 && motion_y == 16'd0))
    else $error("movement step left over after lift");

  a_settling_only_down: assert property (@(posedge clk) disable iff (rst)
    settling |-> contact_down)
    else $error("settling while no contact is down");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

endmodule

// ----- sv/touch_lift_settle_filter.sv -----
// An accepted item passes through the queue and then the output register before
// its result appears on the master side; items waiting ahead of it delay it.
// Throughput: one item per cycle unless the output is stalled; the back part
// retires one queue entry per cycle into a single output register; a
// four-entry queue absorbs stalls. Reset: synchronous; clears the contact state,
// empties the queue and sets settle_ms to 40.
module touch_lift_settle_filter (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] count_read_ok, [8:1] finger_count, [9] coords_read_ok, [17:10] x_high,
  // [25:18] x_low, [33:26] y_high, [41:34] y_low, [73:42] now_ms, [79:74] zero
  input  logic [tlsf_pkg::IN_TDATA_W-1:0]  s_tdata,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] touching, [16:1] x_pos, [32:17] y_pos, [33] ever_seen, [39:34] zero
  output logic [tlsf_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [15:0]       settle_ms;
  tlsf_pkg::item_t   front_item;
  tlsf_pkg::item_t   head_item;
  tlsf_pkg::result_t result;
  logic              q_empty;
  logic              q_full;
  logic              q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms <= tlsf_pkg::SETTLE_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == tlsf_pkg::REG_SETTLE_MS) begin
      settle_ms <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == tlsf_pkg::REG_SETTLE_MS) begin
      prdata = {16'd0, settle_ms};
    end else begin
      prdata = '0;
    end
  end

  tlsf_front u_front (
    .count_read_ok  (s_tdata[0]),
    .finger_count   (s_tdata[8:1]),
    .coords_read_ok (s_tdata[9]),
    .x_high         (s_tdata[17:10]),
    .x_low          (s_tdata[25:18]),
    .y_high         (s_tdata[33:26]),
    .y_low          (s_tdata[41:34]),
    .now_ms         (s_tdata[73:42]),
    .item           (front_item)
  );

  assign s_tready = !q_full;

  tlsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  tlsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .settle_ms  (settle_ms),
    .head_item  (head_item),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {6'd0, result.ever_seen, result.y_pos, result.x_pos, result.touching};

endmodule
